[sv/sso_pkg.sv]
package sso_pkg;

	localparam int unsigned MaxExtent       = 1024;
	localparam int unsigned MaxElementBytes = 16;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] RegRotateMode  = 3'd0;
	localparam logic [2:0] RegVecWidth    = 3'd1;
	localparam logic [2:0] RegPerPhase    = 3'd2;
	localparam logic [2:0] RegMaxPhase    = 3'd3;
	localparam logic [2:0] RegOuterSelect = 3'd4;
	localparam logic [2:0] RegExtentDim0  = 3'd5;
	localparam logic [2:0] RegExtentDim1  = 3'd6;
	localparam logic [2:0] RegElemBytes   = 3'd7;

	localparam int unsigned DivW = 11;

	typedef struct packed {
		logic        ok;
		logic [9:0]  outer;
		logic [9:0]  qi;
		logic [10:0] ri;
		logic [10:0] groups;
	} side_t;

endpackage

[sv/swizzled_shared_byte_offset.sv]
// Swizzled shared-memory byte offset generator.
// Input channel: coord_valid/coord_ready with coord_dim0, coord_dim1.
// Result channel: res_valid/res_ready with byte_offset, valid_res.
// Configuration: APB-style write/read port, register i at byte address 4*i;
// write registers only while no transaction is in flight.
// Pipeline: four chained 11-stage restoring dividers (outer/per_phase with
// inner/vw and extent/vw in parallel, then two divides by max_phase, then the
// swizzle modulo the group count), followed by three multiply/add stages, lie
// between the input transaction and the result on the port.
// Throughput: one transaction per cycle.
// Stall: while a result waits and res_ready is low, the whole pipeline
// holds and coord_ready is low; nothing is dropped or repeated.
// Reset: arst_n clears all valid bits and restores the register reset values
// (rotate 0, vec 1, per_phase 1, max_phase 1, outer dim0, extents 64,
// element bytes 2).
// An out-of-range coordinate or bad configuration gives valid_res 0 and
// byte_offset 0.
module swizzled_shared_byte_offset (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        coord_valid,
	output logic        coord_ready,
	input  logic [9:0]  coord_dim0,
	input  logic [9:0]  coord_dim1,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [24:0] byte_offset,
	output logic        valid_res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned W = sso_pkg::DivW;
	localparam int unsigned L1 = W;
	localparam int unsigned Depth = 4 * W;

	// configuration registers
	logic        rotate_q, outer_sel_q;
	logic [10:0] vec_q, per_q, maxp_q, ext0_q, ext1_q;
	logic [4:0]  eb_q;
	logic        wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotate_q    <= 1'b0;
			vec_q       <= 11'd1;
			per_q       <= 11'd1;
			maxp_q      <= 11'd1;
			outer_sel_q <= 1'b0;
			ext0_q      <= 11'd64;
			ext1_q      <= 11'd64;
			eb_q        <= 5'd2;
		end else if (wr) begin
			case (paddr[4:2])
				sso_pkg::RegRotateMode:  rotate_q    <= pwdata[0];
				sso_pkg::RegVecWidth:    vec_q       <= pwdata[10:0];
				sso_pkg::RegPerPhase:    per_q       <= pwdata[10:0];
				sso_pkg::RegMaxPhase:    maxp_q      <= pwdata[10:0];
				sso_pkg::RegOuterSelect: outer_sel_q <= pwdata[0];
				sso_pkg::RegExtentDim0:  ext0_q      <= pwdata[10:0];
				sso_pkg::RegExtentDim1:  ext1_q      <= pwdata[10:0];
				sso_pkg::RegElemBytes:   eb_q        <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			sso_pkg::RegRotateMode:  prdata = {31'd0, rotate_q};
			sso_pkg::RegVecWidth:    prdata = {21'd0, vec_q};
			sso_pkg::RegPerPhase:    prdata = {21'd0, per_q};
			sso_pkg::RegMaxPhase:    prdata = {21'd0, maxp_q};
			sso_pkg::RegOuterSelect: prdata = {31'd0, outer_sel_q};
			sso_pkg::RegExtentDim0:  prdata = {21'd0, ext0_q};
			sso_pkg::RegExtentDim1:  prdata = {21'd0, ext1_q};
			sso_pkg::RegElemBytes:   prdata = {27'd0, eb_q};
			default:                 prdata = '0;
		endcase
	end

	// pipeline control
	logic             en;
	logic             res_valid_q;
	logic [Depth-1:0] vld_s;
	logic             vld_m1_s, vld_m2_s;

	assign en          = !res_valid_q || res_ready;
	assign coord_ready = en;

	// input checks
	logic [9:0]  outer_in, inner_in;
	logic [10:0] inner_ext;
	logic        ok_in;

	assign outer_in  = outer_sel_q ? coord_dim1 : coord_dim0;
	assign inner_in  = outer_sel_q ? coord_dim0 : coord_dim1;
	assign inner_ext = outer_sel_q ? ext0_q : ext1_q;
	assign ok_in = (vec_q != '0) && (per_q != '0) && (maxp_q != '0) && (eb_q != '0)
		&& ({27'd0, eb_q} <= 32'(sso_pkg::MaxElementBytes))
		&& ({21'd0, ext0_q} <= 32'(sso_pkg::MaxExtent))
		&& ({21'd0, ext1_q} <= 32'(sso_pkg::MaxExtent))
		&& ({1'b0, coord_dim0} < ext0_q) && ({1'b0, coord_dim1} < ext1_q);

	// dividers
	logic [W-1:0] q1, r1, qi, ri, qg, rg, q2, r2, q3, r3, qs, rs;
	logic [W-1:0] x_in;

	sso_div #(.W(W)) u_div_phase (
		.clk(clk), .en(en), .num({1'b0, outer_in}), .den(per_q), .quo(q1), .rem(r1));
	sso_div #(.W(W)) u_div_inner (
		.clk(clk), .en(en), .num({1'b0, inner_in}), .den(vec_q), .quo(qi), .rem(ri));
	sso_div #(.W(W)) u_div_groups (
		.clk(clk), .en(en), .num(inner_ext), .den(vec_q), .quo(qg), .rem(rg));
	sso_div #(.W(W)) u_div_mp0 (
		.clk(clk), .en(en), .num(q1), .den(maxp_q), .quo(q2), .rem(r2));
	sso_div #(.W(W)) u_div_mp1 (
		.clk(clk), .en(en), .num(q2), .den(maxp_q), .quo(q3), .rem(r3));

	// per-item side data travels alongside the dividers
	sso_pkg::side_t side_s [Depth];
	logic [W-1:0]   ph_s   [W];
	sso_pkg::side_t side_in;
	sso_pkg::side_t merged;

	always_comb begin
		side_in       = '0;
		side_in.ok    = ok_in;
		side_in.outer = outer_in;
	end

	always_comb begin
		merged        = side_s[L1-1];
		merged.qi     = qi[9:0];
		merged.ri     = ri;
		merged.groups = qg;
		merged.ok     = side_s[L1-1].ok && (rg == '0) && (qg != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < Depth; k++) begin
				side_s[k] <= (k == L1) ? merged : side_s[k-1];
			end
			ph_s[0] <= r2;
			for (int k = 1; k < W; k++) begin
				ph_s[k] <= ph_s[k-1];
			end
		end
	end

	// swizzle = phase (xor block in rotating mode) mod group count
	assign x_in = rotate_q ? (ph_s[W-1] ^ r3) : ph_s[W-1];

	sso_div #(.W(W)) u_div_swz (
		.clk(clk), .en(en), .num(x_in), .den(side_s[3*W-1].groups), .quo(qs), .rem(rs));

	// multiply / add tail
	logic [20:0] m1_s1, m2_s1;
	logic [10:0] ri_s1;
	logic        ok_s1, ok_s2;
	logic [22:0] sum_s2;
	logic [9:0]  grp;
	logic [27:0] off;
	logic [24:0] byte_offset_q;
	logic        valid_res_q;

	assign grp = side_s[Depth-1].qi ^ rs[9:0];
	assign off = 28'(sum_s2) * 28'(eb_q);

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1  <= 21'(grp) * 21'(vec_q);
			m2_s1  <= 21'(side_s[Depth-1].outer) * 21'(inner_ext);
			ri_s1  <= side_s[Depth-1].ri;
			ok_s1  <= side_s[Depth-1].ok;
			sum_s2 <= 23'(m1_s1) + 23'(m2_s1) + 23'(ri_s1);
			ok_s2  <= ok_s1;
			byte_offset_q <= ok_s2 ? off[24:0] : '0;
			valid_res_q   <= ok_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			vld_m1_s    <= 1'b0;
			vld_m2_s    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[Depth-2:0], coord_valid};
			vld_m1_s    <= vld_s[Depth-1];
			vld_m2_s    <= vld_m1_s;
			res_valid_q <= vld_m2_s;
		end
	end

	assign res_valid   = res_valid_q;
	assign byte_offset = byte_offset_q;
	assign valid_res   = valid_res_q;

	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !valid_res) |-> (byte_offset == '0))
		else $error("nonzero offset on invalid result");

	a_ready_follows_stall: assert property (@(posedge clk) disable iff (!arst_n)
		coord_ready == (!res_valid || res_ready))
		else $error("input ready does not track output stall");

	a_pipe_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({vld_s, vld_m1_s, vld_m2_s}))
		else $error("pipeline moved during stall");

endmodule

[sv/sso_div.sv]
module sso_div #(
	parameter int unsigned W = 11
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);

	// restoring divider, one quotient bit per stage, MSB first
	logic [W-1:0] rem_s [W];
	logic [W-1:0] nq_s  [W];
	logic [W-1:0] den_s [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W-1:0] prem, pnq, pden;
		logic [W:0]   t, nr;
		logic         ge;
		if (k == 0) begin : g_first
			assign prem = '0;
			assign pnq  = num;
			assign pden = den;
		end else begin : g_next
			assign prem = rem_s[k-1];
			assign pnq  = nq_s[k-1];
			assign pden = den_s[k-1];
		end
		assign t  = {prem, pnq[W-1]};
		assign ge = t >= {1'b0, pden};
		assign nr = ge ? t - {1'b0, pden} : t;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= nr[W-1:0];
				nq_s[k]  <= {pnq[W-2:0], ge};
				den_s[k] <= pden;
			end
		end
	end

	assign quo = nq_s[W-1];
	assign rem = rem_s[W-1];

endmodule
